@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by pcap_tap_record_framer; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

@@ design/pcaptf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaptf_pkg
// Types and constants of the 802.15.4 TAP pcap record framer.
// ----------------------------------------------------------------------------
package pcaptf_pkg;

	localparam logic [7:0]  REC_HDR_LEN   = 8'd16;
	localparam logic [7:0]  TAP_HDR_LEN   = 8'd20;
	localparam logic [7:0]  HDR_TOTAL_LEN = 8'd36;
	localparam logic [15:0] MAX_FRAME_LEN = 16'd127;
	localparam logic [7:0]  RECORD_MIN    = 8'd37;

	// TAP TLV codes
	localparam logic [7:0] TLV_RSSI      = 8'd1;
	localparam logic [7:0] TLV_RSSI_LEN  = 8'd4;
	localparam logic [7:0] TLV_CHANNEL   = 8'd3;
	localparam logic [7:0] TLV_CHAN_LEN  = 8'd3;

	// byte offsets within the 36-byte header plus first payload byte
	localparam logic [5:0] HDR_IDX_RSSI    = 6'd24;
	localparam logic [5:0] HDR_IDX_PAYLOAD = 6'd36;

	// float conversion: five halving shift steps, exponent of bit 31 with bias
	localparam logic [2:0] NORM_STEPS = 3'd5;
	localparam logic [7:0] EXP_TOP    = 8'd158;

	typedef struct packed {
		logic        start;
		logic [7:0]  data;
		logic        last;
		logic [7:0]  reclen;
		logic [31:0] seconds;
		logic [19:0] microseconds;
		logic [31:0] rssi;
		logic [15:0] channel;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic in_header;
		logic emit_rssi;
		logic norm_done;
	} bk_status_t;

	typedef enum logic [0:0] {
		BK_IDLE,
		BK_HEADER
	} bk_state_t;

endpackage

@@ design/pcap_tap_record_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcap_tap_record_framer
// Frames captured 802.15.4 bytes into pcap records with a TAP header.
// ----------------------------------------------------------------------------
// One payload byte enters per cycle while the queue of QUEUE_DEPTH words has
// room, and one record byte leaves per cycle while out_stall is low. A frame of
// N bytes yields 36 + N output bytes (16-byte record header, 20-byte TAP header,
// payload), so the output port sets the sustained rate, and the input sees stall
// during each header burst once the queue fills. The first record byte is read
// from the queue entry and then registered; the RSSI float is built by a shift
// normalizer while the timestamp bytes go out. Dropped frames and zero-length
// first bytes are taken at one per cycle while the queue has room, with no
// output. There is no clearing pass after reset. The user must write
// buffer_capacity via cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcap_tap_record_framer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         payload_byte,
	input  logic [6:0]         payload_length,
	input  logic signed [31:0] signal_strength_dbm,
	input  logic [15:0]        radio_channel,
	input  logic [31:0]        capture_seconds,
	input  logic [19:0]        capture_microseconds,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               last_of_record,
	output logic [7:0]         record_length
);

	pcaptf_pkg::q_status_t  q_stat;
	pcaptf_pkg::q_entry_t   push_entry;
	pcaptf_pkg::q_entry_t   head;
	pcaptf_pkg::bk_status_t bk_stat;
	logic push;
	logic pop;

	pcaptf_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.payload_byte         (payload_byte),
		.payload_length       (payload_length),
		.signal_strength_dbm  (signal_strength_dbm),
		.radio_channel        (radio_channel),
		.capture_seconds      (capture_seconds),
		.capture_microseconds (capture_microseconds),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_data             (cfg_data),
		.q_stat               (q_stat),
		.push                 (push),
		.push_entry           (push_entry)
	);

	pcaptf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	pcaptf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_stat         (q_stat),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.last_of_record (last_of_record),
		.record_length  (record_length),
		.bk_stat        (bk_stat)
	);

	`ASSERT_NEVER(a_push_full, clk, arst_n, push && q_stat.full, "push into full queue")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_stat.empty, "pop from empty queue")
	`ASSERT_NEVER(a_pop_in_hdr, clk, arst_n, pop && bk_stat.in_header, "pop during header")
	`ASSERT_ALWAYS(a_rssi_ready, clk, arst_n,
		bk_stat.emit_rssi |-> bk_stat.norm_done, "RSSI sent before normalize done")
	`ASSERT_ALWAYS(a_reclen_min, clk, arst_n,
		out_valid |-> (record_length >= pcaptf_pkg::RECORD_MIN), "record length below minimum")

endmodule

@@ design/pcaptf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaptf_front
// Accepts payload bytes, tracks frame position, decides drop and pushes
// frame-start descriptors and continuation bytes into the queue.
// ----------------------------------------------------------------------------
module pcaptf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            payload_byte,
	input  logic [6:0]            payload_length,
	input  logic signed [31:0]    signal_strength_dbm,
	input  logic [15:0]           radio_channel,
	input  logic [31:0]           capture_seconds,
	input  logic [19:0]           capture_microseconds,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data,
	input  pcaptf_pkg::q_status_t q_stat,
	output logic                  push,
	output pcaptf_pkg::q_entry_t  push_entry
);

	logic [15:0] capacity_q;
	logic [6:0]  pos_q;
	logic [6:0]  expected_q;
	logic        dropping_q;

	logic        accept;
	logic        first;
	logic [7:0]  reclen_first;
	logic        drop_first;
	logic [6:0]  pos_inc;
	logic        last_cont;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_stat.full;
	assign accept    = in_valid && !q_stat.full;
	assign first     = (pos_q == 7'd0);

	assign reclen_first = pcaptf_pkg::HDR_TOTAL_LEN + {1'b0, payload_length};
	assign drop_first   = ({9'd0, payload_length} > pcaptf_pkg::MAX_FRAME_LEN) ||
		({8'd0, reclen_first} > capacity_q);
	assign pos_inc   = pos_q + 7'd1;
	assign last_cont = (pos_inc >= expected_q);

	always_comb begin
		push_entry              = '0;
		push_entry.data         = payload_byte;
		push_entry.seconds      = capture_seconds;
		push_entry.microseconds = capture_microseconds;
		push_entry.rssi         = signal_strength_dbm;
		push_entry.channel      = radio_channel;
		if (first) begin
			push_entry.start  = 1'b1;
			push_entry.last   = (payload_length == 7'd1);
			push_entry.reclen = reclen_first;
			push              = accept && (payload_length != 7'd0) && !drop_first;
		end else begin
			push_entry.start  = 1'b0;
			push_entry.last   = last_cont;
			push_entry.reclen = pcaptf_pkg::HDR_TOTAL_LEN + {1'b0, expected_q};
			push              = accept && !dropping_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 7'd0;
			expected_q <= 7'd0;
			dropping_q <= 1'b0;
		end else if (accept) begin
			if (first) begin
				// a zero-length first byte is swallowed
				if (payload_length != 7'd0) begin
					expected_q <= payload_length;
					dropping_q <= drop_first;
					pos_q      <= (payload_length <= 7'd1) ? 7'd0 : 7'd1;
				end
			end else begin
				pos_q <= last_cont ? 7'd0 : pos_inc;
			end
		end
	end

endmodule

@@ design/pcaptf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaptf_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module pcaptf_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pcaptf_pkg::q_entry_t  push_entry,
	input  logic                  pop,
	output pcaptf_pkg::q_entry_t  head,
	output pcaptf_pkg::q_status_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcaptf_pkg::q_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign head         = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/pcaptf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaptf_back
// Drains the queue into the output register: expands frame-start entries
// into the 36 header bytes plus first payload byte, passes other bytes.
// ----------------------------------------------------------------------------
module pcaptf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcaptf_pkg::q_entry_t   head,
	input  pcaptf_pkg::q_status_t  q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   last_of_record,
	output logic [7:0]             record_length,
	output pcaptf_pkg::bk_status_t bk_stat
);

	pcaptf_pkg::bk_state_t state_q, state_d;
	pcaptf_pkg::q_entry_t  lat_q;
	logic [5:0]  idx_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [7:0]  out_reclen_q;

	// float normalizer
	logic [31:0] norm_mag_q;
	logic [4:0]  norm_shift_q;
	logic [2:0]  norm_step_q;
	logic        norm_sign_q;
	logic        norm_zero_q;

	logic        adv;
	logic        emit;
	logic        load;
	logic [7:0]  emit_byte;
	logic        emit_last;
	logic [7:0]  emit_reclen;
	logic [7:0]  caplen;
	logic [31:0] flt;
	logic [31:0] abs_rssi;

	assign adv    = !out_valid_q || !out_stall;
	assign caplen = lat_q.reclen - pcaptf_pkg::REC_HDR_LEN;
	assign flt    = norm_zero_q ? 32'd0 :
		{norm_sign_q, pcaptf_pkg::EXP_TOP - {3'd0, norm_shift_q}, norm_mag_q[30:8]};
	assign abs_rssi = head.rssi[31] ? (~head.rssi + 32'd1) : head.rssi;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcaptf_pkg::BK_IDLE: begin
				if (!q_stat.empty && adv && head.start) begin
					state_d = pcaptf_pkg::BK_HEADER;
				end
			end
			pcaptf_pkg::BK_HEADER: begin
				if (adv && idx_q == pcaptf_pkg::HDR_IDX_PAYLOAD) begin
					state_d = pcaptf_pkg::BK_IDLE;
				end
			end
			default: state_d = pcaptf_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop         = 1'b0;
		emit        = 1'b0;
		load        = 1'b0;
		emit_byte   = 8'd0;
		emit_last   = 1'b0;
		emit_reclen = lat_q.reclen;
		case (state_q)
			pcaptf_pkg::BK_IDLE: begin
				if (!q_stat.empty && adv) begin
					pop         = 1'b1;
					emit        = 1'b1;
					emit_reclen = head.reclen;
					if (head.start) begin
						// first header byte goes straight from the queue head
						load      = 1'b1;
						emit_byte = head.seconds[7:0];
					end else begin
						emit_byte = head.data;
						emit_last = head.last;
					end
				end
			end
			pcaptf_pkg::BK_HEADER: begin
				if (adv) begin
					emit = 1'b1;
					case (idx_q)
						6'd0:  emit_byte = lat_q.seconds[7:0];
						6'd1:  emit_byte = lat_q.seconds[15:8];
						6'd2:  emit_byte = lat_q.seconds[23:16];
						6'd3:  emit_byte = lat_q.seconds[31:24];
						6'd4:  emit_byte = lat_q.microseconds[7:0];
						6'd5:  emit_byte = lat_q.microseconds[15:8];
						6'd6:  emit_byte = {4'd0, lat_q.microseconds[19:16]};
						6'd8:  emit_byte = caplen;
						6'd12: emit_byte = caplen;
						6'd18: emit_byte = pcaptf_pkg::TAP_HDR_LEN;
						6'd20: emit_byte = pcaptf_pkg::TLV_RSSI;
						6'd22: emit_byte = pcaptf_pkg::TLV_RSSI_LEN;
						6'd24: emit_byte = flt[7:0];
						6'd25: emit_byte = flt[15:8];
						6'd26: emit_byte = flt[23:16];
						6'd27: emit_byte = flt[31:24];
						6'd28: emit_byte = pcaptf_pkg::TLV_CHANNEL;
						6'd30: emit_byte = pcaptf_pkg::TLV_CHAN_LEN;
						6'd32: emit_byte = lat_q.channel[7:0];
						6'd33: emit_byte = lat_q.channel[15:8];
						6'd36: begin
							emit_byte = lat_q.data;
							emit_last = lat_q.last;
						end
						default: emit_byte = 8'd0;
					endcase
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcaptf_pkg::BK_IDLE;
			idx_q       <= 6'd0;
			norm_step_q <= pcaptf_pkg::NORM_STEPS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				idx_q       <= 6'd1;
				norm_step_q <= 3'd0;
			end else begin
				if (state_q == pcaptf_pkg::BK_HEADER && adv) begin
					idx_q <= idx_q + 6'd1;
				end
				if (norm_step_q != pcaptf_pkg::NORM_STEPS) begin
					norm_step_q <= norm_step_q + 3'd1;
				end
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	// binary-search normalize: shift left by 16, 8, 4, 2, 1 while the top is clear
	always_ff @(posedge clk) begin
		if (load) begin
			lat_q        <= head;
			norm_mag_q   <= abs_rssi;
			norm_shift_q <= 5'd0;
			norm_sign_q  <= head.rssi[31];
			norm_zero_q  <= (head.rssi == 32'd0);
		end else begin
			case (norm_step_q)
				3'd0: if (norm_mag_q[31:16] == 16'd0) begin
					norm_mag_q   <= {norm_mag_q[15:0], 16'd0};
					norm_shift_q <= norm_shift_q + 5'd16;
				end
				3'd1: if (norm_mag_q[31:24] == 8'd0) begin
					norm_mag_q   <= {norm_mag_q[23:0], 8'd0};
					norm_shift_q <= norm_shift_q + 5'd8;
				end
				3'd2: if (norm_mag_q[31:28] == 4'd0) begin
					norm_mag_q   <= {norm_mag_q[27:0], 4'd0};
					norm_shift_q <= norm_shift_q + 5'd4;
				end
				3'd3: if (norm_mag_q[31:30] == 2'd0) begin
					norm_mag_q   <= {norm_mag_q[29:0], 2'd0};
					norm_shift_q <= norm_shift_q + 5'd2;
				end
				3'd4: if (!norm_mag_q[31]) begin
					norm_mag_q   <= {norm_mag_q[30:0], 1'b0};
					norm_shift_q <= norm_shift_q + 5'd1;
				end
				default: begin
					norm_mag_q <= norm_mag_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q   <= emit_byte;
			out_last_q   <= emit_last;
			out_reclen_q <= emit_reclen;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign last_of_record = out_last_q;
	assign record_length  = out_reclen_q;

	assign bk_stat.in_header = (state_q == pcaptf_pkg::BK_HEADER);
	assign bk_stat.emit_rssi = (state_q == pcaptf_pkg::BK_HEADER) && adv &&
		(idx_q == pcaptf_pkg::HDR_IDX_RSSI);
	assign bk_stat.norm_done = (norm_step_q == pcaptf_pkg::NORM_STEPS);

endmodule
